>>> rtl/core/decimal_text_to_fixed_point_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text to fixed point block
// Shared concurrent checks, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define DTFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtfp: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define DTFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtfp: next-cycle check failed");

`endif

>>> rtl/core/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg
// Types, character codes and constants shared by the decimal text parser.
// ----------------------------------------------------------------------------
package dtfp_pkg;

    localparam int DEF_WHOLE_BITS  = 31;
    localparam int DEF_FRAC_DIGITS = 9;
    localparam int DEF_FRAC_BITS   = 32;

    localparam int CH_W       = 8;
    localparam int VALUE_W    = 64;
    localparam int FRAC_ACC_W = 30;
    localparam int FRAC_CNT_W = 4;
    localparam int DIGIT_W    = 4;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    // Parser phase, kept in the datapath.
    typedef enum logic [2:0] {
        PH_SPACE = 3'd0,
        PH_SIGN  = 3'd1,
        PH_INT   = 3'd2,
        PH_FRAC  = 3'd3,
        PH_STOP  = 3'd4
    } t_phase;

    // Sequencer state of the controller.
    typedef enum logic [2:0] {
        ST_PARSE = 3'd0,
        ST_LOAD  = 3'd1,
        ST_DIV   = 3'd2,
        ST_MAG   = 3'd3,
        ST_EMIT  = 3'd4
    } t_state;

    typedef struct packed {
        logic parse;     // apply the accepted character to the parser
        logic load_num;  // build the scaled fraction numerator and divisor
        logic div_step;  // one restoring division step
        logic mag_load;  // combine integer part and rounded fraction
        logic out_load;  // clamp, sign and register the result; clear parser
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register is empty or being drained
    } t_dp_stat;

    // Powers of ten for the kept fraction digit count.
    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/core/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Streams ASCII decimal text in, one character per beat, and returns the
// parsed number as signed fixed point with a saturation flag.
// ----------------------------------------------------------------------------
// The block takes one character per input beat and parses it in the cycle it
// is accepted: leading blanks are skipped, a run of plus and minus signs sets
// the sign (each minus flips it), integer digits and an optional point with
// fraction digits follow, and the first character that does not fit stops
// parsing until the beat marked tlast. Every character that is not the last
// one is taken without a stall. After the last character the block takes no
// new character until it has built the scaled fraction, run FRAC_BITS + 1
// steps of a restoring divider that turns the kept decimal fraction into
// binary, merged the integer part, and clamped the value, applied the sign
// and loaded the output register. That divider produces one quotient bit
// per cycle. The result waits in its own register, so the next string can
// start while it is still unread; only a second result arriving before the
// first is taken holds the emit step. The value is two's complement with
// FRAC_BITS fraction bits and is rounded to nearest with ties away from zero;
// fraction digits past FRAC_DIGITS are dropped. An integer part beyond
// 2^WHOLE_BITS, or a magnitude outside the signed range, clamps the value and
// raises the saturation flag. Empty or sign-only text gives zero.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point
    import dtfp_pkg::*;
#(
    parameter int WHOLE_BITS  = DEF_WHOLE_BITS,   // integer bits, 8 to 31
    parameter int FRAC_DIGITS = DEF_FRAC_DIGITS,  // kept fraction digits, 1 to 9
    parameter int FRAC_BITS   = DEF_FRAC_BITS     // binary fraction bits, 8 to 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CH_W-1:0]    s_axis_tdata,   // [7:0] ch
    input  logic               s_axis_tlast,   // last character of the string

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [VALUE_W-1:0] m_axis_tdata,   // [63:0] value
    output logic               m_axis_tuser    // [0] saturated
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller only sequences; all parse state lives in the datapath.
    dtfp_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath owns the output register, so tvalid comes straight from a flop.
    dtfp_datapath #(
        .WHOLE_BITS  (WHOLE_BITS),
        .FRAC_DIGITS (FRAC_DIGITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_ch        (s_axis_tdata),
        .o_value     (m_axis_tdata),
        .o_sat       (m_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

>>> rtl/core/dtfp_datapath.sv
// ----------------------------------------------------------------------------
// dtfp_datapath
// Character parser, fraction divider, range clamp and output register.
// ----------------------------------------------------------------------------
`include "decimal_text_to_fixed_point_assert.svh"

module dtfp_datapath
    import dtfp_pkg::*;
#(
    parameter int WHOLE_BITS  = DEF_WHOLE_BITS,
    parameter int FRAC_DIGITS = DEF_FRAC_DIGITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [CH_W-1:0]    i_ch,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_sat,
    output logic               o_out_valid,
    input  logic               i_out_ready
);

    localparam int WACC_W  = WHOLE_BITS + 1;
    localparam int WPROD_W = WACC_W + 4;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int NUM_W   = FRAC_ACC_W + FRAC_BITS + 1;
    localparam int REM_W   = FRAC_ACC_W + 1;
    localparam int MAG_W   = WHOLE_BITS + FRAC_BITS + 1;

    localparam logic [WPROD_W-1:0] CAP = WPROD_W'(1) << WHOLE_BITS;
    localparam logic [MAG_W-1:0] BOUND = MAG_W'(1) << (WHOLE_BITS + FRAC_BITS);

    // Parser state.
    t_phase                r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [WACC_W-1:0]     r_whole, n_whole;
    logic                  r_ovf, n_ovf;
    logic [FRAC_ACC_W-1:0] r_frac, n_frac;
    logic [FRAC_CNT_W-1:0] r_fcnt, n_fcnt;

    // Divider and result path.
    logic [FRAC_ACC_W-1:0] r_rem;
    logic [Q_W-1:0]        r_num;
    logic [FRAC_ACC_W-1:0] r_pw;
    logic [Q_W-1:0]        r_quot;
    logic [MAG_W-1:0]      r_mag;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_value;
    logic                  r_sat;

    logic                  w_is_digit;
    logic                  w_is_blank;
    logic                  w_is_sign;
    logic [DIGIT_W-1:0]    w_digit;
    logic [WPROD_W-1:0]    w_wprod;
    logic [FRAC_ACC_W-1:0] w_fprod;
    logic [FRAC_ACC_W-1:0] w_pw;
    logic [NUM_W-1:0]      w_num;
    logic [REM_W-1:0]      w_trial;
    logic                  w_ge;
    logic [REM_W-1:0]      w_diff;
    logic                  w_sat;
    logic [MAG_W-1:0]      w_clamped;

    assign w_is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign w_is_blank = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
    assign w_is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
    assign w_digit    = i_ch[DIGIT_W-1:0];

    assign w_wprod = (WPROD_W'(r_whole) << 3) + (WPROD_W'(r_whole) << 1)
                   + WPROD_W'(w_digit);
    assign w_fprod = (r_frac << 3) + (r_frac << 1) + FRAC_ACC_W'(w_digit);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_whole = r_whole;
        n_ovf   = r_ovf;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        if (i_cmd.out_load) begin
            n_phase = PH_SPACE;
            n_neg   = 1'b0;
            n_whole = '0;
            n_ovf   = 1'b0;
            n_frac  = '0;
            n_fcnt  = '0;
        end else if (i_cmd.parse) begin
            case (r_phase)
                PH_STOP: begin
                end
                PH_FRAC: begin
                    if (w_is_digit) begin
                        // Digits past the kept count are dropped.
                        if (r_fcnt < FRAC_CNT_W'(FRAC_DIGITS)) begin
                            n_frac = w_fprod;
                            n_fcnt = r_fcnt + 1'b1;
                        end
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                PH_SPACE, PH_SIGN, PH_INT: begin
                    if (r_phase == PH_SPACE && w_is_blank) begin
                        n_phase = PH_SPACE;
                    end else if (r_phase != PH_INT && w_is_sign) begin
                        n_neg   = r_neg ^ (i_ch == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (w_is_digit) begin
                        // The integer part is held at the cap once it goes past it.
                        if (w_wprod > CAP) begin
                            n_whole = CAP[WACC_W-1:0];
                            n_ovf   = 1'b1;
                        end else begin
                            n_whole = w_wprod[WACC_W-1:0];
                        end
                        n_phase = PH_INT;
                    end else if (i_ch == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end
    end

    // Numerator is the kept fraction scaled by 2^FRAC_BITS plus half the
    // divisor, so the truncating quotient rounds to nearest with ties up.
    assign w_pw  = pow10(r_fcnt);
    assign w_num = (NUM_W'(r_frac) << FRAC_BITS) + NUM_W'(w_pw >> 1);

    assign w_trial = {r_rem, r_num[Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_pw};
    assign w_diff  = w_trial - {1'b0, r_pw};

    always_comb begin
        if (r_neg) begin
            w_sat     = r_ovf || (r_mag > BOUND);
            w_clamped = w_sat ? BOUND : r_mag;
        end else begin
            w_sat     = r_ovf || (r_mag >= BOUND);
            w_clamped = w_sat ? (BOUND - 1'b1) : r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_neg       <= 1'b0;
            r_whole     <= '0;
            r_ovf       <= 1'b0;
            r_frac      <= '0;
            r_fcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_whole <= n_whole;
            r_ovf   <= n_ovf;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_num) begin
            // The quotient stays below 2^Q_W, so the top bits already sit
            // below the divisor and seed the remainder.
            r_rem <= w_num[NUM_W-1:Q_W];
            r_num <= w_num[Q_W-1:0];
            r_pw  <= w_pw;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[FRAC_ACC_W-1:0] : w_trial[FRAC_ACC_W-1:0];
            r_num  <= r_num << 1;
            r_quot <= {r_quot[Q_W-2:0], w_ge};
        end
        if (i_cmd.mag_load) begin
            r_mag <= (MAG_W'(r_whole) << FRAC_BITS) + MAG_W'(r_quot);
        end
        if (i_cmd.out_load) begin
            r_value <= r_neg ? (VALUE_W'(0) - VALUE_W'(w_clamped)) : VALUE_W'(w_clamped);
            r_sat   <= w_sat;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_value         = r_value;
    assign o_sat           = r_sat;
    assign o_out_valid     = r_out_valid;

    `DTFP_ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n, i_cmd.div_step, r_rem < r_pw)
    `DTFP_ASSERT_IMPL(a_whole_capped, i_clk, i_rst_n, 1'b1, WPROD_W'(r_whole) <= CAP)
    `DTFP_ASSERT_IMPL(a_fcnt_limit, i_clk, i_rst_n, 1'b1, r_fcnt <= FRAC_CNT_W'(FRAC_DIGITS))

endmodule

>>> rtl/core/dtfp_ctrl.sv
// ----------------------------------------------------------------------------
// dtfp_ctrl
// Sequencer: character intake, then numerator load, division, merge, emit.
// ----------------------------------------------------------------------------
`include "decimal_text_to_fixed_point_assert.svh"

module dtfp_ctrl
    import dtfp_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_s_tlast,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int STEP_W = $clog2(FRAC_BITS + 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_PARSE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.parse = 1'b1;
                    if (i_s_tlast) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_num = 1'b1;
                n_step         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(FRAC_BITS)) begin
                    n_state = ST_MAG;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MAG: begin
                o_cmd.mag_load = 1'b1;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_PARSE;
                end
            end
            default: begin
                n_state = ST_PARSE;
            end
        endcase
    end

    `DTFP_ASSERT_NEXT(a_last_stalls_intake, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, !o_s_tready)
    `DTFP_ASSERT_NEXT(a_load_then_divide, i_clk, i_rst_n, o_cmd.load_num, o_cmd.div_step)
    `DTFP_ASSERT_IMPL(a_step_in_range, i_clk, i_rst_n, r_state == ST_DIV, r_step <= STEP_W'(FRAC_BITS))

endmodule
